@@ hw/rtl/cfdt_pkg.sv @@
`timescale 1ns / 1ps

package cfdt_pkg;

  // Default geometry
  localparam int GRID_WIDTH_DEF       = 512;
  localparam int GRID_HEIGHT_DEF      = 512;
  localparam int CELL_BITS_DEF        = 16;
  localparam int TILE_SHIFT_DEF       = 5;
  localparam int CHUNK_SHIFT_BITS_DEF = 8;

  // Activity written on every paint and loaded by the clearing pass
  localparam logic [2:0] ACTIVITY_MARK = 3'd5;

  // Working width for signed coordinates and clipped box edges
  localparam int COORD_W = 13;

  // Width of the painted-cell count
  localparam int COUNT_W = 19;

  typedef enum logic [1:0] {
    CMD_PAINT = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PAINT,
    ST_READ,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic signed [10:0] center_x;
    logic signed [10:0] center_y;
    logic [7:0]         radius;
  } paint_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } paint_stat_t;

  // Number of blocks of size 2^sh that cover len cells
  function automatic int blocks(input int len, input int sh);
    return (len + (1 << sh) - 1) >> sh;
  endfunction

  // Index width for a store of n entries, at least one bit
  function automatic int idx_bits(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

@@ hw/rtl/cfdt_ram.sv @@
`timescale 1ns / 1ps

module cfdt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/cfdt_paint.sv @@
`timescale 1ns / 1ps

module cfdt_paint #(
  parameter int GRID_WIDTH       = cfdt_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT      = cfdt_pkg::GRID_HEIGHT_DEF,
  parameter int TILE_SHIFT       = cfdt_pkg::TILE_SHIFT_DEF,
  parameter int CHUNK_SHIFT_BITS = cfdt_pkg::CHUNK_SHIFT_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       start,
  input  cfdt_pkg::paint_cmd_t                       cmd,
  output cfdt_pkg::paint_stat_t                      stat,
  output logic [cfdt_pkg::COUNT_W-1:0]               count,
  output logic                                       wr_en,
  output logic [$clog2(GRID_WIDTH*GRID_HEIGHT)-1:0]  wr_addr,
  output logic [cfdt_pkg::idx_bits(
    cfdt_pkg::blocks(GRID_WIDTH, TILE_SHIFT) *
    cfdt_pkg::blocks(GRID_HEIGHT, TILE_SHIFT))-1:0]  wr_tile,
  output logic [cfdt_pkg::idx_bits(
    cfdt_pkg::blocks(GRID_WIDTH, CHUNK_SHIFT_BITS) *
    cfdt_pkg::blocks(GRID_HEIGHT, CHUNK_SHIFT_BITS))-1:0] wr_chunk
);

  localparam int CW  = cfdt_pkg::COORD_W;
  localparam int XW  = $clog2(GRID_WIDTH);
  localparam int YW  = $clog2(GRID_HEIGHT);
  localparam int AW  = $clog2(GRID_WIDTH*GRID_HEIGHT);
  localparam int TNX = cfdt_pkg::blocks(GRID_WIDTH, TILE_SHIFT);
  localparam int TNY = cfdt_pkg::blocks(GRID_HEIGHT, TILE_SHIFT);
  localparam int TIW = cfdt_pkg::idx_bits(TNX*TNY);
  localparam int CNX = cfdt_pkg::blocks(GRID_WIDTH, CHUNK_SHIFT_BITS);
  localparam int CNY = cfdt_pkg::blocks(GRID_HEIGHT, CHUNK_SHIFT_BITS);
  localparam int CIW = cfdt_pkg::idx_bits(CNX*CNY);

  // Box clip, evaluated in the start cycle
  logic signed [CW-1:0] cx_e, cy_e, r_e, wlim, hlim;
  logic signed [CW-1:0] x0s, x1s, y0s, y1s, x0c, x1c, y0c, y1c;
  logic                 empty;

  assign cx_e = {{(CW-11){cmd.center_x[10]}}, cmd.center_x};
  assign cy_e = {{(CW-11){cmd.center_y[10]}}, cmd.center_y};
  assign r_e  = {{(CW-8){1'b0}}, cmd.radius};
  assign wlim = CW'(GRID_WIDTH);
  assign hlim = CW'(GRID_HEIGHT);
  assign x0s  = cx_e - r_e;
  assign x1s  = cx_e + r_e;
  assign y0s  = cy_e - r_e;
  assign y1s  = cy_e + r_e;
  assign x0c  = (x0s < 0) ? '0 : x0s;
  assign y0c  = (y0s < 0) ? '0 : y0s;
  assign x1c  = (x1s > wlim) ? wlim : x1s;
  assign y1c  = (y1s > hlim) ? hlim : y1s;
  assign empty = (x1c <= x0c) || (y1c <= y0c);

  // Scan state
  logic                 busy_r, act_r;
  logic [XW-1:0]        x_r, xl_r;
  logic [YW-1:0]        y_r, y0_r, yl_r;
  logic signed [CW-1:0] cx_r, cy_r;
  logic [15:0]          r2_r;
  logic [cfdt_pkg::COUNT_W-1:0] cnt_r;
  logic                 last_pt, done;

  // Distance stage
  logic signed [CW-1:0] dx, dy;
  logic signed [8:0]    dx9, dy9;
  logic signed [17:0]   dxw, dyw;
  logic [17:0]          sqx, sqy, d2_nxt;
  logic [AW-1:0]        addr_nxt;
  logic [TIW-1:0]       tile_nxt;
  logic [CIW-1:0]       chunk_nxt;

  logic                 p1_vld_r;
  logic [17:0]          p1_d2_r;
  logic [AW-1:0]        p1_addr_r;
  logic [TIW-1:0]       p1_tile_r;
  logic [CIW-1:0]       p1_chunk_r;

  assign dx  = $signed({{(CW-XW){1'b0}}, x_r}) - cx_r;
  assign dy  = $signed({{(CW-YW){1'b0}}, y_r}) - cy_r;
  // offsets stay within [-r, r-1] inside the box
  assign dx9 = dx[8:0];
  assign dy9 = dy[8:0];
  // widen before squaring so the product keeps all its bits
  assign dxw = 18'(dx9);
  assign dyw = 18'(dy9);
  assign sqx = 18'(dxw * dxw);
  assign sqy = 18'(dyw * dyw);
  assign d2_nxt    = sqx + sqy;
  assign addr_nxt  = AW'(AW'(y_r) * AW'(GRID_WIDTH)) + AW'(x_r);
  assign tile_nxt  = TIW'(TIW'(y_r >> TILE_SHIFT) * TIW'(TNX)) + TIW'(x_r >> TILE_SHIFT);
  assign chunk_nxt = CIW'(CIW'(y_r >> CHUNK_SHIFT_BITS) * CIW'(CNX))
                   + CIW'(x_r >> CHUNK_SHIFT_BITS);

  assign last_pt = act_r && (y_r == yl_r) && (x_r == xl_r);
  assign done    = busy_r && !act_r && !p1_vld_r && !start;
  assign wr_en   = p1_vld_r && (p1_d2_r <= {2'b00, r2_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      act_r    <= 1'b0;
      p1_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= act_r;
      if (start) begin
        busy_r <= 1'b1;
        act_r  <= !empty;
      end else begin
        if (last_pt) begin
          act_r <= 1'b0;
        end
        if (done) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= XW'(x0c);
      y_r   <= YW'(y0c);
      y0_r  <= YW'(y0c);
      xl_r  <= XW'(x1c - 1);
      yl_r  <= YW'(y1c - 1);
      cx_r  <= cx_e;
      cy_r  <= cy_e;
      r2_r  <= {8'd0, cmd.radius} * {8'd0, cmd.radius};
      cnt_r <= '0;
    end else begin
      // advance rows inside a column, then step the column
      if (act_r) begin
        if (y_r == yl_r) begin
          y_r <= y0_r;
          x_r <= x_r + 1'b1;
        end else begin
          y_r <= y_r + 1'b1;
        end
      end
      if (wr_en) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
    p1_d2_r    <= d2_nxt;
    p1_addr_r  <= addr_nxt;
    p1_tile_r  <= tile_nxt;
    p1_chunk_r <= chunk_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done;
  assign count     = cnt_r;
  assign wr_addr   = p1_addr_r;
  assign wr_tile   = p1_tile_r;
  assign wr_chunk  = p1_chunk_r;

endmodule

@@ hw/rtl/circle_fill_with_dirty_tiles_unit.sv @@
`timescale 1ns / 1ps

// Filled-circle painter over a cell grid, with tile activity and chunk dirty marks.
// Input channel (in_*): one command item per handshake; in_tuser carries the
// command (paint, read, clear chunk flag), in_tdata the coordinates and values.
// Result channel (out_*): exactly one result item per accepted command.
// Paint writes every cell of the clipped box [c-r, c+r) within distance r of the
// center; the scan visits one cell of that box per cycle, so a paint's scan covers
// N cells, N being the clipped box area (4096 for radius 32 fully on grid), and
// no scan runs when the clipped box is empty.
// The single write port of the cell memory sets that rate.
// An on-grid read passes through the read state for the registered memory read; an
// off-grid read, a clear and an unused code go straight to the result state.
// One command is in work at a time; the output register holds a finished result
// while the next command is accepted. When the receiver stalls, the result stays
// in the output register and a second finished result waits inside the block,
// which then takes no new item.
// After reset a clearing pass writes zero to every cell and the activity mark to
// every tile, during which in_tready is low. Chunk dirty flags reset at once.
module circle_fill_with_dirty_tiles_unit #(
  parameter int GRID_WIDTH       = cfdt_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT      = cfdt_pkg::GRID_HEIGHT_DEF,
  parameter int CELL_BITS        = cfdt_pkg::CELL_BITS_DEF,
  parameter int TILE_SHIFT       = cfdt_pkg::TILE_SHIFT_DEF,
  parameter int CHUNK_SHIFT_BITS = cfdt_pkg::CHUNK_SHIFT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // center_x[10:0], center_y[21:11], radius[29:22], paint_value[45:30], zero[47:46]
  input  logic [47:0] in_tdata,
  // command[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_value[15:0], tile_activity[18:16], chunk_dirty[19], cells_painted[38:20],
  // out_of_range[39]
  output logic [39:0] out_tdata
);

  localparam int CW    = cfdt_pkg::COORD_W;
  localparam int XW    = $clog2(GRID_WIDTH);
  localparam int YW    = $clog2(GRID_HEIGHT);
  localparam int NCELL = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW    = $clog2(NCELL);
  localparam int TNX   = cfdt_pkg::blocks(GRID_WIDTH, TILE_SHIFT);
  localparam int TNY   = cfdt_pkg::blocks(GRID_HEIGHT, TILE_SHIFT);
  localparam int TN    = TNX * TNY;
  localparam int TIW   = cfdt_pkg::idx_bits(TN);
  localparam int CNX   = cfdt_pkg::blocks(GRID_WIDTH, CHUNK_SHIFT_BITS);
  localparam int CNY   = cfdt_pkg::blocks(GRID_HEIGHT, CHUNK_SHIFT_BITS);
  localparam int CN    = CNX * CNY;
  localparam int CIW   = cfdt_pkg::idx_bits(CN);

  // Input decode
  cfdt_pkg::cmd_t       in_cmd;
  cfdt_pkg::paint_cmd_t pcmd;
  logic signed [CW-1:0] cx_e, cy_e;
  logic                 on_grid;
  logic [XW-1:0]        rd_x;
  logic [YW-1:0]        rd_y;
  logic [AW-1:0]        rd_addr;
  logic [TIW-1:0]       rd_tile;
  logic [CIW-1:0]       rd_chunk;
  logic                 accept;

  assign in_cmd        = cfdt_pkg::cmd_t'(in_tuser);
  assign pcmd.center_x = in_tdata[10:0];
  assign pcmd.center_y = in_tdata[21:11];
  assign pcmd.radius   = in_tdata[29:22];
  assign cx_e = {{(CW-11){in_tdata[10]}}, in_tdata[10:0]};
  assign cy_e = {{(CW-11){in_tdata[21]}}, in_tdata[21:11]};
  assign on_grid = (cx_e >= 0) && (cx_e < $signed(CW'(GRID_WIDTH)))
                && (cy_e >= 0) && (cy_e < $signed(CW'(GRID_HEIGHT)));
  // low coordinate bits are the cell position whenever on_grid holds
  assign rd_x     = in_tdata[XW-1:0];
  assign rd_y     = in_tdata[11+YW-1:11];
  assign rd_addr  = AW'(AW'(rd_y) * AW'(GRID_WIDTH)) + AW'(rd_x);
  assign rd_tile  = TIW'(TIW'(rd_y >> TILE_SHIFT) * TIW'(TNX)) + TIW'(rd_x >> TILE_SHIFT);
  assign rd_chunk = CIW'(CIW'(rd_y >> CHUNK_SHIFT_BITS) * CIW'(CNX))
                  + CIW'(rd_x >> CHUNK_SHIFT_BITS);

  // Control
  cfdt_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]    clr_cnt_r;
  logic             clr_busy, out_load, pnt_start;
  logic             out_tvalid_r;
  logic [39:0]      out_tdata_r;

  // Paint engine
  cfdt_pkg::paint_stat_t        pstat;
  logic [cfdt_pkg::COUNT_W-1:0] pcount;
  logic                         pnt_wr_en;
  logic [AW-1:0]                pnt_addr;
  logic [TIW-1:0]               pnt_tile;
  logic [CIW-1:0]               pnt_chunk;

  // Stores
  logic                 cell_we, tile_we;
  logic [AW-1:0]        cell_waddr;
  logic [CELL_BITS-1:0] cell_wdata, cell_rdata;
  logic [TIW-1:0]       tile_waddr;
  logic [2:0]           tile_rdata;
  logic [CN-1:0]        chunk_r;
  logic [CELL_BITS-1:0] val_r;

  // Result staging
  logic [15:0]                  res_val_r;
  logic [2:0]                   res_act_r;
  logic                         res_dirty_r, res_oor_r;
  logic [cfdt_pkg::COUNT_W-1:0] res_cnt_r;

  assign accept = in_tvalid && in_tready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cfdt_pkg::ST_CLEAR: begin
        if (clr_cnt_r == AW'(NCELL - 1)) begin
          state_nxt = cfdt_pkg::ST_IDLE;
        end
      end
      cfdt_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          case (in_cmd)
            cfdt_pkg::CMD_PAINT: state_nxt = cfdt_pkg::ST_PAINT;
            cfdt_pkg::CMD_READ:  state_nxt = on_grid ? cfdt_pkg::ST_READ : cfdt_pkg::ST_RESP;
            default:             state_nxt = cfdt_pkg::ST_RESP;
          endcase
        end
      end
      cfdt_pkg::ST_PAINT: begin
        if (pstat.done) begin
          state_nxt = cfdt_pkg::ST_RESP;
        end
      end
      cfdt_pkg::ST_READ: state_nxt = cfdt_pkg::ST_RESP;
      cfdt_pkg::ST_RESP: begin
        if (out_load) begin
          state_nxt = cfdt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cfdt_pkg::ST_CLEAR;
    endcase
  end

  // State outputs
  always_comb begin
    in_tready = 1'b0;
    clr_busy  = 1'b0;
    out_load  = 1'b0;
    pnt_start = 1'b0;
    case (state_r)
      cfdt_pkg::ST_CLEAR: clr_busy = 1'b1;
      cfdt_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        pnt_start = in_tvalid && (in_cmd == cfdt_pkg::CMD_PAINT);
      end
      cfdt_pkg::ST_RESP: out_load = !out_tvalid_r || out_tready;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= cfdt_pkg::ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (clr_busy) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  cfdt_paint #(
    .GRID_WIDTH       (GRID_WIDTH),
    .GRID_HEIGHT      (GRID_HEIGHT),
    .TILE_SHIFT       (TILE_SHIFT),
    .CHUNK_SHIFT_BITS (CHUNK_SHIFT_BITS)
  ) u_paint (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (pnt_start),
    .cmd      (pcmd),
    .stat     (pstat),
    .count    (pcount),
    .wr_en    (pnt_wr_en),
    .wr_addr  (pnt_addr),
    .wr_tile  (pnt_tile),
    .wr_chunk (pnt_chunk)
  );

  // Writes come from the clearing pass or the paint scan; a read command's read is
  // taken at its accept, when neither writes, so it never meets a write to that entry.
  assign cell_we    = clr_busy || pnt_wr_en;
  assign cell_waddr = clr_busy ? clr_cnt_r : pnt_addr;
  assign cell_wdata = clr_busy ? '0 : val_r;
  assign tile_we    = (clr_busy && (clr_cnt_r < AW'(TN))) || pnt_wr_en;
  assign tile_waddr = clr_busy ? TIW'(clr_cnt_r) : pnt_tile;

  cfdt_ram #(
    .WIDTH (CELL_BITS),
    .DEPTH (NCELL)
  ) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (rd_addr),
    .rdata (cell_rdata)
  );

  cfdt_ram #(
    .WIDTH (3),
    .DEPTH (TN)
  ) u_tile_ram (
    .clk   (clk),
    .we    (tile_we),
    .waddr (tile_waddr),
    .wdata (cfdt_pkg::ACTIVITY_MARK),
    .raddr (rd_tile),
    .rdata (tile_rdata)
  );

  // Chunk dirty flags: set by painted cells, dropped by a clear on grid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_r <= '0;
    end else if (pnt_wr_en) begin
      chunk_r[pnt_chunk] <= 1'b1;
    end else if (accept && (in_cmd == cfdt_pkg::CMD_CLEAR) && on_grid) begin
      chunk_r[rd_chunk] <= 1'b0;
    end
  end

  // Result staging
  always_ff @(posedge clk) begin
    if (accept) begin
      val_r       <= CELL_BITS'(in_tdata[45:30]);
      res_val_r   <= '0;
      res_act_r   <= '0;
      res_dirty_r <= 1'b0;
      res_cnt_r   <= '0;
      res_oor_r   <= 1'b0;
      case (in_cmd)
        cfdt_pkg::CMD_READ: begin
          if (on_grid) begin
            res_dirty_r <= chunk_r[rd_chunk];
          end else begin
            res_oor_r <= 1'b1;
          end
        end
        cfdt_pkg::CMD_CLEAR: res_oor_r <= !on_grid;
        default: begin
          res_oor_r <= 1'b0;
        end
      endcase
    end
    if (state_r == cfdt_pkg::ST_READ) begin
      res_val_r <= 16'(cell_rdata);
      res_act_r <= tile_rdata;
    end
    if ((state_r == cfdt_pkg::ST_PAINT) && pstat.done) begin
      res_cnt_r <= pcount;
    end
  end

  // Output register: hold while stalled, load from staging when free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {res_oor_r, res_cnt_r, res_dirty_r, res_act_r, res_val_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_paint_write_in_paint: assert property (@(posedge clk) disable iff (!rst_n)
    pnt_wr_en |-> (state_r == cfdt_pkg::ST_PAINT))
    else $error("paint write outside paint state");

  a_read_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cfdt_pkg::ST_READ) |-> $past(in_tvalid && in_tready))
    else $error("read state without accepted item");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cfdt_pkg::ST_CLEAR) |-> !out_tvalid_r)
    else $error("result shown during clearing pass");

  a_paint_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    pnt_start |=> pstat.busy)
    else $error("paint engine not busy after start");

  a_reset_enters_clear: assert property (@(posedge clk)
    !rst_n |=> (state_r == cfdt_pkg::ST_CLEAR))
    else $error("reset did not start clearing pass");

endmodule

@@ dv/circle_fill_with_dirty_tiles_unit_tb.sv @@
`timescale 1ns / 1ps

module circle_fill_with_dirty_tiles_unit_tb;
  import cfdt_pkg::*;

  localparam int GRID_W   = GRID_WIDTH_DEF;
  localparam int GRID_H   = GRID_HEIGHT_DEF;
  localparam int T_SHIFT  = TILE_SHIFT_DEF;
  localparam int C_SHIFT  = CHUNK_SHIFT_BITS_DEF;
  localparam int TILES_X  = (GRID_W + (1 << T_SHIFT) - 1) >> T_SHIFT;
  localparam int TILES_Y  = (GRID_H + (1 << T_SHIFT) - 1) >> T_SHIFT;
  localparam int CHUNKS_X = (GRID_W + (1 << C_SHIFT) - 1) >> C_SHIFT;
  localparam int CHUNKS_Y = (GRID_H + (1 << C_SHIFT) - 1) >> C_SHIFT;

  // Command code the block must treat as a no-op
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Generous bound: clearing pass plus the biggest paints, many times over
  localparam int CYCLE_LIMIT = 16_000_000;
  // Cycles to watch for stray result items after the last one arrived
  localparam int TAIL_CYCLES = 64;
  // Length of the single long receiver hold-off
  localparam int HOLD_CYCLES = 400;
  // Random items after the directed ones
  localparam int RANDOM_ITEMS = 116;

  // Result item as it sits in out_tdata, lowest field last
  typedef struct packed {
    logic        out_of_range;
    logic [18:0] cells_painted;
    logic        chunk_dirty;
    logic [2:0]  tile_activity;
    logic [15:0] read_value;
  } result_t;

  // Shadow copy of grid, tile activity and chunk flags, plus the queue of
  // result items the block still owes
  class grid_scoreboard;
    bit [15:0] cells [GRID_W * GRID_H];
    bit [2:0]  activity [TILES_X * TILES_Y];
    bit        dirty [CHUNKS_X * CHUNKS_Y];
    result_t   expected_results [$];
    int        errors;
    int        results_checked;
    int        n_paint, n_read, n_clear, n_unused, n_off_grid;
    longint    cells_total;

    function new();
      foreach (activity[i]) activity[i] = ACTIVITY_MARK;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function int tile_of(int x, int y);
      return (y >> T_SHIFT) * TILES_X + (x >> T_SHIFT);
    endfunction

    function int chunk_of(int x, int y);
      return (y >> C_SHIFT) * CHUNKS_X + (x >> C_SHIFT);
    endfunction

    function bit on_grid(int x, int y);
      return x >= 0 && x < GRID_W && y >= 0 && y < GRID_H;
    endfunction

    // Fill the disc over the clipped half-open box, return the cells written
    function int paint_disc(int cx, int cy, int r, bit [15:0] code);
      int x_lo, x_hi, y_lo, y_hi, n;
      x_lo = (cx - r < 0) ? 0 : cx - r;
      y_lo = (cy - r < 0) ? 0 : cy - r;
      x_hi = (cx + r > GRID_W) ? GRID_W : cx + r;
      y_hi = (cy + r > GRID_H) ? GRID_H : cy + r;
      n = 0;
      for (int x = x_lo; x < x_hi; x++) begin
        for (int y = y_lo; y < y_hi; y++) begin
          if ((x - cx) * (x - cx) + (y - cy) * (y - cy) <= r * r) begin
            cells[y * GRID_W + x]   = code;
            activity[tile_of(x, y)] = ACTIVITY_MARK;
            dirty[chunk_of(x, y)]   = 1'b1;
            n++;
          end
        end
      end
      return n;
    endfunction

    // Work out the result of an accepted command item and queue it
    function void note_command(logic [1:0] code, logic signed [10:0] cx_f,
                               logic signed [10:0] cy_f, logic [7:0] r_f,
                               logic [15:0] val_f);
      int      cx;
      int      cy;
      result_t res;
      cx  = cx_f;
      cy  = cy_f;
      res = '0;
      case (code)
        CMD_PAINT: begin
          res.cells_painted = 19'(paint_disc(cx, cy, int'(r_f), val_f));
          n_paint++;
          cells_total += res.cells_painted;
        end
        CMD_READ: begin
          n_read++;
          if (on_grid(cx, cy)) begin
            res.read_value    = cells[cy * GRID_W + cx];
            res.tile_activity = activity[tile_of(cx, cy)];
            res.chunk_dirty   = dirty[chunk_of(cx, cy)];
          end else begin
            res.out_of_range = 1'b1;
            n_off_grid++;
          end
        end
        CMD_CLEAR: begin
          n_clear++;
          if (on_grid(cx, cy)) begin
            dirty[chunk_of(cx, cy)] = 1'b0;
          end else begin
            res.out_of_range = 1'b1;
            n_off_grid++;
          end
        end
        default: begin
          n_unused++;
        end
      endcase
      expected_results.insert(expected_results.size(), res);
    endfunction

    // Compare a result item with the oldest expectation, field by field
    function void check_result(logic [39:0] raw);
      result_t got;
      result_t exp;
      got = raw;
      if (expected_results.size() == 0) begin
        $error("result item with nothing expected: out_tdata=%h", raw);
        errors++;
        return;
      end
      exp = expected_results.pop_front();
      results_checked++;
      if (got.read_value !== exp.read_value) begin
        $error("read_value: expected %0d, got %0d", exp.read_value, got.read_value);
        errors++;
      end
      if (got.tile_activity !== exp.tile_activity) begin
        $error("tile_activity: expected %0d, got %0d", exp.tile_activity,
               got.tile_activity);
        errors++;
      end
      if (got.chunk_dirty !== exp.chunk_dirty) begin
        $error("chunk_dirty: expected %0d, got %0d", exp.chunk_dirty, got.chunk_dirty);
        errors++;
      end
      if (got.cells_painted !== exp.cells_painted) begin
        $error("cells_painted: expected %0d, got %0d", exp.cells_painted,
               got.cells_painted);
        errors++;
      end
      if (got.out_of_range !== exp.out_of_range) begin
        $error("out_of_range: expected %0d, got %0d", exp.out_of_range,
               got.out_of_range);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;

  grid_scoreboard sb = new();

  // Center of the latest paint, so that reads often land on painted cells
  int last_cx;
  int last_cy;
  int last_r;

  circle_fill_with_dirty_tiles_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: the block never finishing is a failure
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[circle_fill_with_dirty_tiles_unit] ERROR");
    $finish;
  end

  // Sample accepted result items at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      sb.check_result(out_tdata);
    end
  end

  // Present one command item at the falling edge, hold it until accepted
  task automatic send_command(logic [1:0] code, int cx, int cy, int r, int val);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= code;
    in_tdata  <= {2'b00, val[15:0], r[7:0], cy[10:0], cx[10:0]};
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    sb.note_command(code, cx[10:0], cy[10:0], r[7:0], val[15:0]);
    if (code == CMD_PAINT) begin
      last_cx = cx;
      last_cy = cy;
      last_r  = r;
    end
  endtask

  // Drop valid for a number of cycles
  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
  endtask

  // Hold off new items until every owed result item has come back
  task automatic drain_results();
    idle_cycles(1);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // One random command: mostly well-placed paints and reads near them,
  // a few clears, unused codes and wild coordinates
  task automatic send_random_command();
    int pick;
    int cx;
    int cy;
    int r;
    pick = $urandom_range(0, 99);
    r    = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 72) : $urandom_range(0, 24);
    cx   = $urandom_range(0, GRID_W + 127) - 64;
    cy   = $urandom_range(0, GRID_H + 127) - 64;
    if (pick < 5) begin
      // anything anywhere, full coordinate range, small radius
      send_command(2'($urandom_range(0, 3)), $urandom_range(0, 2047) - 1024,
                   $urandom_range(0, 2047) - 1024, $urandom_range(0, 16),
                   $urandom_range(0, 65535));
    end else if (pick < 55) begin
      send_command(CMD_PAINT, cx, cy, r, $urandom_range(0, 65535));
    end else if (pick < 82) begin
      if ($urandom_range(0, 1) == 1) begin
        // land inside or around the latest disc
        cx = last_cx + $urandom_range(0, 2 * last_r + 2) - last_r - 1;
        cy = last_cy + $urandom_range(0, 2 * last_r + 2) - last_r - 1;
      end
      send_command(CMD_READ, cx, cy, 0, $urandom_range(0, 65535));
    end else if (pick < 96) begin
      send_command(CMD_CLEAR, cx, cy, $urandom_range(0, 255), $urandom_range(0, 65535));
    end else begin
      send_command(CMD_UNUSED, cx, cy, r, $urandom_range(0, 65535));
    end
  endtask

  // Receiver: stall on its own pattern, with one long hold-off
  initial begin : receiver
    int  mode;
    bit  held;
    held       = 1'b0;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      mode = $urandom_range(0, 3);
      for (int k = 0; k < 64; k++) begin
        @(negedge clk);
        if (!held && sb.results_checked >= 60) begin
          // starve the output so the block fills up and stalls its input
          held = 1'b1;
          out_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
        end else begin
          case (mode)
            0:       out_tready <= 1'b1;
            1:       out_tready <= ($urandom_range(0, 2) != 0);
            2:       out_tready <= (k % 4 == 3);
            default: out_tready <= (k >= 32);
          endcase
        end
      end
    end
  end

  // Sender and end of run
  initial begin : sender
    int sent;
    int burst;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = CMD_PAINT;
    last_cx   = 0;
    last_cy   = 0;
    last_r    = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: fresh state, extremes, clipping, off-grid cases, no-op code
    send_command(CMD_READ, 0, 0, 0, 0);
    send_command(CMD_READ, GRID_W - 1, GRID_H - 1, 255, 16'hFFFF);
    send_command(CMD_PAINT, 0, 0, 0, 16'hFFFF);          // zero radius
    send_command(CMD_PAINT, 100, 100, 1, 16'hFFFF);
    send_command(CMD_PAINT, 0, 0, 255, 16'hA5A5);        // largest radius, clipped
    send_command(CMD_READ, 0, 0, 0, 0);
    send_command(CMD_READ, 254, 0, 0, 0);
    send_command(CMD_READ, 100, 100, 0, 0);
    send_command(CMD_PAINT, GRID_W - 1, GRID_H - 1, 40, 16'h5A5A);
    send_command(CMD_READ, GRID_W - 1, GRID_H - 1, 0, 0);
    send_command(CMD_PAINT, -1024, -1024, 255, 16'h0001);  // wholly off grid
    send_command(CMD_PAINT, 1023, 1023, 255, 16'h8000);
    send_command(CMD_PAINT, -5, 300, 12, 16'h1234);        // partly off grid
    send_command(CMD_READ, -1, 0, 0, 0);
    send_command(CMD_READ, GRID_W, 5, 0, 0);
    send_command(CMD_READ, 1023, -1024, 0, 0);
    send_command(CMD_CLEAR, 0, 0, 0, 0);
    send_command(CMD_CLEAR, -1024, 1023, 0, 0);
    send_command(CMD_CLEAR, 600, 600, 0, 0);
    send_command(CMD_READ, 10, 10, 0, 0);
    send_command(CMD_UNUSED, 5, 5, 9, 16'h1234);
    send_command(CMD_READ, 5, 5, 0, 0);
    send_command(CMD_CLEAR, 300, 300, 0, 0);
    send_command(CMD_READ, GRID_W - 1, GRID_H - 1, 0, 0);

    drain_results();

    // Random: bursts of random length with random gaps, draining once halfway
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst; i++) begin
        send_random_command();
        sent++;
      end
      if (sent >= RANDOM_ITEMS / 2 && sent - burst < RANDOM_ITEMS / 2) begin
        drain_results();
      end else begin
        idle_cycles($urandom_range(0, 15));
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d paints writing %0d cells, %0d reads, %0d clears,",
             sb.n_paint, sb.cells_total, sb.n_read, sb.n_clear);
    $display("%0d no-op codes and %0d off-grid reads or clears", sb.n_unused,
             sb.n_off_grid);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[circle_fill_with_dirty_tiles_unit] OK");
    end else begin
      $display("[circle_fill_with_dirty_tiles_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/cfdt_pkg.sv
hw/rtl/cfdt_ram.sv
hw/rtl/cfdt_paint.sv
hw/rtl/circle_fill_with_dirty_tiles_unit.sv
dv/circle_fill_with_dirty_tiles_unit_tb.sv
